>>> rtl/sfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfa_pkg;

	localparam int MASK_W  = 10;
	localparam int LIMIT_W = 8;
	localparam int COUNT_W = 16;
	localparam int SLOT_W  = 4;
	localparam int CFG_AW  = 2;

	localparam logic [LIMIT_W-1:0] LOSS_LIMIT_RST = 8'd100;

	typedef enum logic [1:0] {
		MODE_PACKET  = 2'd0,
		MODE_TIMEOUT = 2'd1,
		MODE_RECORD  = 2'd2,
		MODE_ACCEL   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_IMU     = 2'd0,
		KIND_ACCEL   = 2'd1,
		KIND_STRETCH = 2'd2,
		KIND_OTHER   = 2'd3
	} kind_t;

	typedef enum logic [CFG_AW-1:0] {
		REG_FRAME_MASK = 2'd0,
		REG_ACCEL_MASK = 2'd1,
		REG_LOSS_LIMIT = 2'd2,
		REG_UNUSED     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [1:0]         packet_kind;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] frame_count;
	} item_t;

	typedef struct packed {
		logic              frame_ready;
		logic [MASK_W-1:0] frame_flags;
		logic              dropped;
		logic [MASK_W-1:0] disconnect_mask;
		logic              accel_done;
		logic              restart_timer;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/sensor_frame_assembler.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser: mode, packet_kind; tdata: slot, frame_count
// m_*      out  m_tvalid/m_tready  tuser: frame_ready; tdata: flags, dropped, disc, ...
// cfg_*    in   cfg_we             cfg_addr selects register, cfg_wdata
//
// One word per cycle sustained while m_tready stays high.
// Input register, combinational state update, result register; the state is
// updated when the input register hands its word to the result register.
// Reset clears all flags, counters and valids at once; no sweep.
// A stalled m_tready holds the result and backs up into s_tready.

module sensor_frame_assembler #(
	parameter int SLOT_COUNT = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // slot[3:0], frame_count[19:4], zero pad
	input  wire logic [3:0]  s_tuser,  // mode[1:0], packet_kind[3:2]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // frame_flags[9:0], dropped[10],
	                                   // disconnect_mask[20:11], accel_done[21],
	                                   // restart_timer[22], zero pad
	output logic             m_tuser,  // frame_ready
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [9:0]  cfg_wdata
);
	import sfa_pkg::*;

	logic    valid_s1, valid_s2, adv, fire;
	item_t   item_s1;
	result_t res, res_s2;

	assign adv      = !valid_s2 || m_tready;
	assign fire     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.mode        <= s_tuser[1:0];
			item_s1.packet_kind <= s_tuser[3:2];
			item_s1.slot        <= s_tdata[3:0];
			item_s1.frame_count <= s_tdata[19:4];
		end
	end

	sfa_core #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.item      (item_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.frame_ready;
	assign m_tdata  = {1'b0, res_s2.restart_timer, res_s2.accel_done,
		res_s2.disconnect_mask, res_s2.dropped, res_s2.frame_flags};

endmodule

`default_nettype wire

>>> rtl/sfa_miss_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module sfa_miss_lane (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       upd,
	input  wire logic                       clr,
	input  wire logic                       miss,
	input  wire logic [sfa_pkg::LIMIT_W-1:0] loss_limit,
	output logic                            disc
);
	import sfa_pkg::*;

	logic [LIMIT_W-1:0] cnt_q;
	logic [LIMIT_W:0]   inc;

	// missed count plus one, wraps to zero at the loss limit
	assign inc  = {1'b0, cnt_q} + 1'b1;
	assign disc = miss && (inc >= {1'b0, loss_limit});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (clr) begin
			cnt_q <= '0;
		end else if (upd) begin
			if (!miss || disc) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= inc[LIMIT_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/sfa_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sfa_core #(
	parameter int SLOT_COUNT = 10
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [sfa_pkg::CFG_AW-1:0]  cfg_addr,
	input  wire logic [sfa_pkg::MASK_W-1:0]  cfg_wdata,
	input  wire logic                        fire,
	input  wire sfa_pkg::item_t              item,
	output sfa_pkg::result_t                 res
);
	import sfa_pkg::*;

	localparam int SC = SLOT_COUNT;
	localparam int SW = (SC > 1) ? $clog2(SC) : 1;
	localparam int CW = (SC > MASK_W) ? SC : MASK_W;

	logic [MASK_W-1:0]  frame_mask_q;
	logic [MASK_W-1:0]  accel_mask_q;
	logic [LIMIT_W-1:0] loss_limit_q;

	logic [SC-1:0]      rcv_q, rcv_d, rcv_a;
	logic [SC-1:0]      acc_q, acc_d, acc_a;
	logic               tp_q, tp_d;
	logic               fs_q, fs_d;
	logic [COUNT_W-1:0] left_q, left_d;

	logic               busy, slot_ok, match_n, match_a, hit, fs_a;
	logic               cnt_upd, cnt_clr;
	logic [SC-1:0]      miss, disc;
	logic [SW-1:0]      sidx;
	result_t            r;

	assign busy    = (left_q != '0);
	assign slot_ok = ({1'b0, item.slot} < (SLOT_W + 1)'(SC));
	assign sidx    = item.slot[SW-1:0];

	always_comb begin
		rcv_a = rcv_q;
		acc_a = acc_q;
		r     = '0;
		if (item.mode == MODE_PACKET) begin
			if (item.packet_kind == KIND_IMU && !busy) begin
				if (slot_ok) begin
					if (rcv_q[sidx]) begin
						r.dropped = 1'b1;
					end else begin
						rcv_a[sidx] = 1'b1;
					end
				end
			end else if (item.packet_kind == KIND_ACCEL && busy) begin
				if (slot_ok) begin
					acc_a[sidx] = 1'b1;
				end
			end else if (item.packet_kind == KIND_STRETCH && !busy) begin
				rcv_a[SC-1] = 1'b1;
			end
		end
	end

	assign match_n = (CW'(rcv_a) == CW'(frame_mask_q));
	assign match_a = (CW'(acc_a) == CW'(accel_mask_q));
	assign hit     = match_n || tp_q;
	assign fs_a    = match_n || fs_q;
	assign miss    = ~rcv_a;

	always_comb begin
		rcv_d   = rcv_q;
		acc_d   = acc_q;
		tp_d    = tp_q;
		fs_d    = fs_q;
		left_d  = left_q;
		cnt_upd = 1'b0;
		cnt_clr = 1'b0;
		res     = r;
		case (item.mode)
			MODE_TIMEOUT: begin
				tp_d = 1'b1;
			end
			MODE_RECORD: begin
				fs_d              = 1'b0;
				rcv_d             = '0;
				cnt_clr           = 1'b1;
				tp_d              = 1'b0;
				left_d            = '0;
				res.restart_timer = 1'b1;
			end
			MODE_ACCEL: begin
				fs_d    = 1'b0;
				acc_d   = '0;
				rcv_d   = '0;
				cnt_clr = 1'b1;
				left_d  = item.frame_count;
				tp_d    = 1'b0;
			end
			default: begin
				rcv_d = rcv_a;
				acc_d = acc_a;
				if (hit) begin
					cnt_upd           = tp_q;
					cnt_clr           = match_n;
					tp_d              = 1'b0;
					fs_d              = fs_a;
					res.restart_timer = 1'b1;
					if (tp_q) begin
						res.disconnect_mask = MASK_W'(CW'(disc));
					end
					if (fs_a) begin
						res.frame_ready = 1'b1;
						res.frame_flags = MASK_W'(CW'(rcv_a));
						rcv_d           = '0;
					end
				end
				if (busy && match_a) begin
					res.frame_ready = 1'b1;
					res.frame_flags = MASK_W'(CW'(acc_a));
					acc_d           = '0;
					left_d          = left_q - 1'b1;
					res.accel_done  = (left_q == COUNT_W'(1));
				end
			end
		endcase
	end

	for (genvar i = 0; i < SC; i++) begin : g_lane
		sfa_miss_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.upd        (fire && cnt_upd),
			.clr        (fire && cnt_clr),
			.miss       (miss[i]),
			.loss_limit (loss_limit_q),
			.disc       (disc[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mask_q <= '0;
			accel_mask_q <= '0;
			loss_limit_q <= LOSS_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_FRAME_MASK: frame_mask_q <= cfg_wdata;
				REG_ACCEL_MASK: accel_mask_q <= cfg_wdata;
				REG_LOSS_LIMIT: loss_limit_q <= cfg_wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcv_q  <= '0;
			acc_q  <= '0;
			tp_q   <= 1'b0;
			fs_q   <= 1'b0;
			left_q <= '0;
		end else if (fire) begin
			rcv_q  <= rcv_d;
			acc_q  <= acc_d;
			tp_q   <= tp_d;
			fs_q   <= fs_d;
			left_q <= left_d;
		end
	end

endmodule

`default_nettype wire
